// ===== sv/eaat_pkg.sv =====
package eaat_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int HANDLE_W  = 4;
   localparam int BLK_W     = 32;

   localparam logic [1:0] CMD_OPEN  = 2'd0;
   localparam logic [1:0] CMD_XLATE = 2'd1;
   localparam logic [1:0] CMD_QUERY = 2'd2;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_NO_SPACE = 3'd1;
   localparam logic [2:0] ST_NO_HDL   = 3'd2;
   localparam logic [2:0] ST_RANGE    = 3'd3;
   localparam logic [2:0] ST_EMPTY    = 3'd4;

   typedef struct packed {
      logic [1:0]          cmd;
      logic [BLK_W-1:0]    alloc_blocks;
      logic [HANDLE_W-1:0] client_handle;
      logic [BLK_W-1:0]    block_offset;
      logic [BLK_W-1:0]    block_count;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic [HANDLE_W-1:0] handle_out;
      logic [BLK_W-1:0]    phys_base;
      logic [BLK_W-1:0]    extent_len;
      logic [BLK_W-1:0]    free_blocks;
   } rsp_type;

   typedef struct packed {
      logic              found;
      logic [SLOT_W-1:0] slot;
   } pick_type;

   typedef struct packed {
      logic              commit;
      logic [SLOT_W-1:0] slot;
      logic [BLK_W-1:0]  base;
      logic [BLK_W-1:0]  length;
   } slot_wr_type;

   typedef struct packed {
      logic             used;
      logic [BLK_W-1:0] base;
      logic [BLK_W-1:0] length;
   } slot_rd_type;

endpackage

// ===== sv/eaat_pick.sv =====
module eaat_pick (
   input  logic [eaat_pkg::NUM_SLOTS-1:0] used,
   input  logic [eaat_pkg::SLOT_W-1:0]    hint,
   output eaat_pkg::pick_type             pick
);
   import eaat_pkg::*;

   logic [SLOT_W-1:0] first;
   logic              any_free;
   logic              hint_free;

   always_comb begin
      first    = '0;
      any_free = 1'b0;
      for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
         if (!used[i]) begin
            first    = SLOT_W'(i);
            any_free = 1'b1;
         end
      end
   end

   assign hint_free  = !used[hint];
   assign pick.found = hint_free || any_free;
   assign pick.slot  = hint_free ? hint : first;

endmodule

// ===== sv/eaat_table.sv =====
module eaat_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [eaat_pkg::SLOT_W-1:0]   rd_slot,
   output eaat_pkg::slot_rd_type         rd,
   output eaat_pkg::pick_type            pick,
   input  eaat_pkg::slot_wr_type         wr
);
   import eaat_pkg::*;

   logic [NUM_SLOTS-1:0] used_ff, used_in;
   logic [SLOT_W-1:0]    hint_ff, hint_in;
   logic [BLK_W-1:0]     base_ff [NUM_SLOTS];
   logic [BLK_W-1:0]     len_ff  [NUM_SLOTS];

   eaat_pick u_pick (
      .used (used_ff),
      .hint (hint_ff),
      .pick (pick)
   );

   always_comb begin
      used_in = used_ff;
      hint_in = hint_ff;
      if (wr.commit) begin
         used_in[wr.slot] = 1'b1;
         hint_in = (wr.slot == SLOT_W'(NUM_SLOTS - 1)) ? '0 : wr.slot + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         hint_ff <= '0;
      end else begin
         used_ff <= used_in;
         hint_ff <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.commit) begin
         base_ff[wr.slot] <= wr.base;
         len_ff[wr.slot]  <= wr.length;
      end
   end

   assign rd.used   = used_ff[rd_slot];
   assign rd.base   = base_ff[rd_slot];
   assign rd.length = len_ff[rd_slot];

   a_commit_marks_used: assert property (@(posedge clock) disable iff (reset)
      wr.commit |=> used_ff[$past(wr.slot)])
      else $error("committed slot not marked used");

   a_commit_moves_hint: assert property (@(posedge clock) disable iff (reset)
      wr.commit && (wr.slot != SLOT_W'(NUM_SLOTS - 1)) |=> hint_ff == $past(wr.slot) + 1'b1)
      else $error("hint did not follow committed slot");

endmodule

// ===== sv/extent_allocate_and_translate_top.sv =====
// An accepted request beat is held in the request register, its response beat
// in the response register. Throughput: one request per cycle unless rsp_ready
// stalls; the slot search, bound checks and pointer bump settle between them.
// Reset (synchronous, active high) clears the partition size, free pointer,
// handle hint, slot in-use bits and both valid registers.
module extent_allocate_and_translate_top (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  eaat_pkg::req_type           req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output eaat_pkg::rsp_type           rsp_data,
   input  logic                        csr_wr_en,
   input  logic [eaat_pkg::BLK_W-1:0]  csr_wr_data
);
   import eaat_pkg::*;

   logic                in_valid_ff, in_valid_in;
   req_type             in_data_ff, in_data_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic [BLK_W-1:0]    part_ff, part_in;
   logic [BLK_W-1:0]    next_free_ff, next_free_in;

   logic                adv;
   logic [BLK_W-1:0]    left;
   logic                handle_ok;
   logic [BLK_W:0]      span;
   rsp_type             res;
   slot_wr_type         wr;
   slot_rd_type         rd;
   pick_type            pick;

   eaat_table u_table (
      .clock   (clock),
      .reset   (reset),
      .rd_slot (SLOT_W'(in_data_ff.client_handle)),
      .rd      (rd),
      .pick    (pick),
      .wr      (wr)
   );

   assign adv       = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || adv;

   assign left      = (part_ff > next_free_ff) ? part_ff - next_free_ff : '0;
   assign handle_ok = 32'(in_data_ff.client_handle) < 32'(NUM_SLOTS);
   assign span      = {1'b0, in_data_ff.block_offset} + {1'b0, in_data_ff.block_count};

   always_comb begin
      res             = '0;
      res.status      = ST_OK;
      res.free_blocks = left;
      wr              = '0;
      case (in_data_ff.cmd)
         CMD_OPEN: begin
            if (left == '0 || in_data_ff.alloc_blocks > left) begin
               res.status = ST_NO_SPACE;
            end else if (!pick.found) begin
               res.status = ST_NO_HDL;
            end else begin
               res.handle_out  = HANDLE_W'(pick.slot);
               res.phys_base   = next_free_ff;
               res.extent_len  = in_data_ff.alloc_blocks;
               res.free_blocks = left - in_data_ff.alloc_blocks;
               wr.commit       = adv;
               wr.slot         = pick.slot;
               wr.base         = next_free_ff;
               wr.length       = in_data_ff.alloc_blocks;
            end
         end
         CMD_XLATE: begin
            if (!handle_ok || !rd.used) begin
               res.status = ST_EMPTY;
            end else if (span > {1'b0, rd.length}) begin
               res.status = ST_RANGE;
            end else begin
               res.phys_base  = rd.base + in_data_ff.block_offset;
               res.extent_len = in_data_ff.block_count;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_data_in   = in_data_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (adv) begin
         in_valid_in  = 1'b0;
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_data_in  = req_data;
      end
      part_in      = csr_wr_en ? csr_wr_data : part_ff;
      next_free_in = wr.commit ? next_free_ff + in_data_ff.alloc_blocks : next_free_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         part_ff      <= '0;
         next_free_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         part_ff      <= part_in;
         next_free_ff <= next_free_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_pointer_monotonic: assert property (@(posedge clock) disable iff (reset)
      $past(!reset) |-> next_free_ff >= $past(next_free_ff))
      else $error("free pointer moved backward");

   a_commit_reports_ok: assert property (@(posedge clock) disable iff (reset)
      wr.commit |=> rsp_valid_ff && rsp_data_ff.status == ST_OK)
      else $error("slot committed without ok response");

   a_commit_needs_slot: assert property (@(posedge clock) disable iff (reset)
      wr.commit |-> pick.found && adv && in_data_ff.cmd == CMD_OPEN)
      else $error("commit without a free slot");

   a_stalled_beat_holds: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !adv |=> in_valid_ff && in_data_ff == $past(in_data_ff))
      else $error("held request beat lost");

endmodule
